// ===== src/status_led_blink_controller_unit_defines.svh =====
// Assertion macros shared by the status LED blink controller RTL.
`ifndef STATUS_LED_BLINK_CONTROLLER_UNIT_DEFINES_SVH
`define STATUS_LED_BLINK_CONTROLLER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SBLC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SBLC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/sblc_pkg.sv =====
// Types, codes, reset values and state map of the status LED blink controller.
package sblc_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int CFG_WIDTH   = 16;
	localparam int NUM_REGS    = 8;
	localparam int REG_IDX_W   = 3;
	localparam int APB_ADDR_W  = REG_IDX_W + 2;
	localparam int APB_DATA_W  = 32;
	localparam int CMP_W       = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

	typedef logic [3:0] mode_t;
	typedef logic [3:0] sys_state_t;
	typedef logic [CFG_WIDTH-1:0] cfg_word_t;

	// LED mode codes
	localparam mode_t MODE_OFF     = 4'd0;
	localparam mode_t MODE_ON      = 4'd1;
	localparam mode_t MODE_SLOW_X1 = 4'd2;
	localparam mode_t MODE_SLOW_X3 = 4'd4;
	localparam mode_t MODE_SLOW    = 4'd5;
	localparam mode_t MODE_FAST_X1 = 4'd6;
	localparam mode_t MODE_FAST_X3 = 4'd8;
	localparam mode_t MODE_FAST    = 4'd9;

	// system state codes
	localparam sys_state_t ST_POWER_ON   = 4'd0;
	localparam sys_state_t ST_INITED     = 4'd1;
	localparam sys_state_t ST_WORKING    = 4'd2;
	localparam sys_state_t ST_RECONNECT  = 4'd3;
	localparam sys_state_t ST_POWER_OFF  = 4'd4;
	localparam sys_state_t ST_TESTING    = 4'd5;
	localparam sys_state_t ST_TEST_OK    = 4'd6;
	localparam sys_state_t ST_ERR_ALL    = 4'd7;
	localparam sys_state_t ST_ERR_MAIN   = 4'd8;
	localparam sys_state_t ST_ERR_EXT    = 4'd9;
	localparam sys_state_t ST_EXT_POWER  = 4'd10;
	localparam sys_state_t ST_BATT_RELAY = 4'd11;
	localparam sys_state_t ST_BATT_VLOW  = 4'd12;
	localparam sys_state_t ST_BATT_SHUT  = 4'd13;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_G_SLOW_ON  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_G_SLOW_PER = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_G_FAST_ON  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_G_FAST_PER = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_R_SLOW_ON  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_R_SLOW_PER = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_R_FAST_ON  = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_R_FAST_PER = 3'd7;

	localparam cfg_word_t CFG_RESET [NUM_REGS] = '{
		16'd50, 16'd100, 16'd10, 16'd20, 16'd50, 16'd100, 16'd10, 16'd20
	};

	typedef struct packed {
		cfg_word_t slow_on;
		cfg_word_t slow_period;
		cfg_word_t fast_on;
		cfg_word_t fast_period;
	} led_cfg_t;

	typedef struct packed {
		mode_t                  mode;
		mode_t                  seen;
		logic [COUNT_WIDTH-1:0] count;
		logic [1:0]             reps;
		logic                   level;
	} led_state_t;

	// mode load request into one LED channel
	typedef struct packed {
		logic  wr;
		mode_t wdata;
	} led_ctl_t;

	typedef struct packed {
		logic  hit;
		mode_t mode;
	} map_t;

	localparam led_state_t GREEN_RESET = '{
		mode: MODE_OFF, seen: MODE_OFF, count: '0, reps: 2'd0, level: 1'b0
	};
	localparam led_state_t RED_RESET = '{
		mode: MODE_ON, seen: MODE_ON, count: '0, reps: 2'd0, level: 1'b0
	};

	function automatic map_t green_map(sys_state_t st);
		map_t m;
		m.hit = 1'b1;
		unique case (st)
			ST_INITED:    m.mode = MODE_SLOW;
			ST_WORKING:   m.mode = MODE_ON;
			ST_RECONNECT: m.mode = MODE_FAST;
			ST_POWER_OFF: m.mode = MODE_FAST_X3;
			ST_TESTING:   m.mode = MODE_FAST;
			ST_TEST_OK:   m.mode = MODE_ON;
			ST_ERR_ALL:   m.mode = MODE_OFF;
			ST_ERR_MAIN:  m.mode = MODE_OFF;
			ST_ERR_EXT:   m.mode = MODE_ON;
			default: begin
				m.hit  = 1'b0;
				m.mode = MODE_OFF;
			end
		endcase
		return m;
	endfunction

	function automatic map_t red_map(sys_state_t st);
		map_t m;
		m.hit = 1'b1;
		unique case (st)
			ST_TESTING:    m.mode = MODE_FAST;
			ST_TEST_OK:    m.mode = MODE_ON;
			ST_ERR_ALL:    m.mode = MODE_OFF;
			ST_ERR_MAIN:   m.mode = MODE_ON;
			ST_ERR_EXT:    m.mode = MODE_OFF;
			ST_EXT_POWER:  m.mode = MODE_ON;
			ST_BATT_RELAY: m.mode = MODE_SLOW;
			ST_BATT_VLOW:  m.mode = MODE_FAST;
			ST_BATT_SHUT:  m.mode = MODE_OFF;
			default: begin
				m.hit  = 1'b0;
				m.mode = MODE_OFF;
			end
		endcase
		return m;
	endfunction

endpackage

// ===== src/sblc_cfg_regs.sv =====
// APB register file holding the flash on-counts and periods of both LEDs.
module sblc_cfg_regs
	import sblc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output led_cfg_t              green_cfg,
	output led_cfg_t              red_cfg
);

	cfg_word_t               regs_q [NUM_REGS];
	logic [REG_IDX_W-1:0]    idx;
	logic                    wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[APB_ADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) regs_q[i] <= CFG_RESET[i];
		end else if (wr_en) begin
			regs_q[idx] <= pwdata[CFG_WIDTH-1:0];
		end
	end

	assign prdata = APB_DATA_W'(regs_q[idx]);

	assign green_cfg = '{
		slow_on: regs_q[REG_G_SLOW_ON], slow_period: regs_q[REG_G_SLOW_PER],
		fast_on: regs_q[REG_G_FAST_ON], fast_period: regs_q[REG_G_FAST_PER]
	};
	assign red_cfg = '{
		slow_on: regs_q[REG_R_SLOW_ON], slow_period: regs_q[REG_R_SLOW_PER],
		fast_on: regs_q[REG_R_FAST_ON], fast_period: regs_q[REG_R_FAST_PER]
	};

endmodule

// ===== src/sblc_led_next.sv =====
// Next-state logic of one LED channel: mode load, repeat counting and flash timing.
module sblc_led_next
	import sblc_pkg::*;
(
	input  led_state_t cur,
	input  led_ctl_t   ctl,
	input  led_cfg_t   cfg,
	output led_state_t nxt
);

	mode_t                  m;
	logic                   changed;
	logic                   slow;
	logic                   finite;
	logic [COUNT_WIDTH-1:0] c;
	logic [CMP_W-1:0]       c_x;
	logic [CMP_W-1:0]       on_x;
	logic [CMP_W-1:0]       per_x;
	logic [1:0]             reps;
	logic [1:0]             reps_dec;

	assign m       = ctl.wr ? ctl.wdata : cur.mode;
	assign changed = (m != cur.seen);
	assign c       = changed ? '0 : cur.count;
	assign slow    = (m <= MODE_SLOW);
	assign finite  = (m != MODE_SLOW) && (m != MODE_FAST);
	assign c_x     = CMP_W'(c);
	assign on_x    = CMP_W'(slow ? cfg.slow_on : cfg.fast_on);
	assign per_x   = CMP_W'(slow ? cfg.slow_period : cfg.fast_period);
	assign reps_dec = reps - 2'd1;

	always_comb begin
		reps = cur.reps;
		if (changed) begin
			if (m >= MODE_SLOW_X1 && m <= MODE_SLOW_X3)
				reps = 2'(m - MODE_ON);
			else if (m >= MODE_FAST_X1 && m <= MODE_FAST_X3)
				reps = 2'(m - MODE_SLOW);
		end
	end

	always_comb begin
		nxt = cur;
		if (m > MODE_FAST) begin
			// unknown code: drop to off, everything else holds
			nxt.mode = MODE_OFF;
		end else begin
			nxt.mode  = m;
			nxt.seen  = m;
			nxt.reps  = reps;
			nxt.count = c;
			if (m == MODE_OFF) begin
				nxt.level = 1'b0;
			end else if (m == MODE_ON) begin
				nxt.level = 1'b1;
			end else begin
				priority if (c_x == '0) begin
					nxt.level = 1'b1;
					nxt.count = c + 1'b1;
				end else if (c_x == on_x) begin
					nxt.level = 1'b0;
					nxt.count = c + 1'b1;
				end else if (c_x >= per_x) begin
					nxt.count = '0;
					if (finite) begin
						nxt.reps = reps_dec;
						if (reps_dec == 2'd0) nxt.mode = MODE_OFF;
					end
				end else begin
					nxt.count = c + 1'b1;
				end
			end
		end
	end

endmodule

// ===== src/status_led_blink_controller_unit.sv =====
// Top level of the status LED blink controller: stream ports, state map, LED state and result.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata: tick with state and mode writes
//  m_      | out | m_tvalid/m_tready  | m_tdata: LED levels and modes
//  apb     | in  | psel/penable/pready| 8 x 16-bit flash timing registers
//
// One tick per cycle sustained while m_tready stays high; each tick passes the input register,
// then the result register, with the whole state update done between them in one pass.
// arst_n resets all LED and system state and both valid flags, and loads the registers with their reset values.
// With m_tready low the result holds and one more beat waits in the input
// register; s_tready falls only when both are full.
module status_led_blink_controller_unit
	import sblc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [0] state_write, [4:1] new_state, [5] green_write, [9:6] green_mode_in,
	// [10] red_write, [14:11] red_mode_in, [15] zero
	input  logic [15:0]           s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [0] green_led, [1] red_led, [5:2] green_mode_out, [9:6] red_mode_out,
	// [15:10] zero
	output logic [15:0]           m_tdata,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	`include "status_led_blink_controller_unit_defines.svh"

	led_cfg_t   green_cfg;
	led_cfg_t   red_cfg;

	logic       in_valid_s1;
	logic [14:0] in_s1;
	logic       out_valid_q;
	logic [9:0] out_q;
	logic       advance;

	sys_state_t sys_state_q;
	sys_state_t sys_seen_q;
	led_state_t green_q;
	led_state_t red_q;
	led_state_t green_nxt;
	led_state_t red_nxt;

	sys_state_t st_n;
	sys_state_t seen_pre;
	sys_state_t seen_n;
	map_t       gmap;
	map_t       rmap;
	logic       map_hit;
	led_ctl_t   green_ctl;
	led_ctl_t   red_ctl;

	sblc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.green_cfg (green_cfg),
		.red_cfg   (red_cfg)
	);

	assign advance  = in_valid_s1 & (~out_valid_q | m_tready);
	assign s_tready = ~in_valid_s1 | advance;

	// state load, then direct writes, then the state map (map wins)
	assign st_n     = in_s1[0] ? in_s1[4:1] : sys_state_q;
	assign seen_pre = in_s1[0] ? sys_state_q : sys_seen_q;
	assign gmap     = green_map(st_n);
	assign rmap     = red_map(st_n);
	assign map_hit  = (st_n != seen_pre) && (gmap.hit || rmap.hit);
	assign seen_n   = map_hit ? st_n : seen_pre;

	assign green_ctl.wr    = (map_hit & gmap.hit) | in_s1[5];
	assign green_ctl.wdata = (map_hit & gmap.hit) ? gmap.mode : in_s1[9:6];
	assign red_ctl.wr      = (map_hit & rmap.hit) | in_s1[10];
	assign red_ctl.wdata   = (map_hit & rmap.hit) ? rmap.mode : in_s1[14:11];

	sblc_led_next u_green (
		.cur (green_q),
		.ctl (green_ctl),
		.cfg (green_cfg),
		.nxt (green_nxt)
	);

	sblc_led_next u_red (
		.cur (red_q),
		.ctl (red_ctl),
		.cfg (red_cfg),
		.nxt (red_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			sys_state_q <= ST_POWER_ON;
			sys_seen_q  <= ST_POWER_ON;
			green_q     <= GREEN_RESET;
			red_q       <= RED_RESET;
		end else begin
			if (s_tready) in_valid_s1 <= s_tvalid;
			if (advance) begin
				out_valid_q <= 1'b1;
				sys_state_q <= st_n;
				sys_seen_q  <= seen_n;
				green_q     <= green_nxt;
				red_q       <= red_nxt;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) in_s1 <= s_tdata[14:0];
		if (advance) out_q <= {red_nxt.mode, green_nxt.mode, red_nxt.level, green_nxt.level};
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_q};

	`SBLC_ASSERT_NOW(a_full_stall, in_valid_s1 && out_valid_q && !m_tready, !s_tready, "input taken while both stages are full")
	`SBLC_ASSERT_NEXT(a_adv_result, advance, m_tvalid, "advanced beat produced no result")
	`SBLC_ASSERT_NEXT(a_accept_s1, s_tvalid && s_tready, in_valid_s1, "accepted beat lost from input stage")
	`SBLC_ASSERT_NOW(a_mode_range, m_tvalid, (m_tdata[5:2] <= MODE_FAST) && (m_tdata[9:6] <= MODE_FAST), "result mode outside the known codes")

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the status LED blink controller: stream ticks in, LED state out.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import sblc_pkg::*;

	// tick fields, lowest bit last
	typedef struct packed {
		mode_t      red_mode_in;
		logic       red_write;
		mode_t      green_mode_in;
		logic       green_write;
		sys_state_t new_state;
		logic       state_write;
	} tick_t;

	typedef struct packed {
		mode_t red_mode;
		mode_t green_mode;
		logic  red_led;
		logic  green_led;
	} led_view_t;

	localparam sys_state_t ST_SHUTDOWN = 4'd14;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int HOLD_CYCLES = 300;
	localparam int SHOWN_MAX   = 10;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [15:0]           s_tdata  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [15:0]           m_tdata;
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [APB_ADDR_W-1:0] paddr    = '0;
	logic [APB_DATA_W-1:0] pwdata   = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	status_led_blink_controller_unit uut (.*);

	always #2 clk = ~clk;

	// predictor state
	cfg_word_t  timing_regs [NUM_REGS] = CFG_RESET;
	led_state_t green_st = GREEN_RESET;
	led_state_t red_st   = RED_RESET;
	sys_state_t sys_now   = ST_POWER_ON;
	sys_state_t sys_acted = ST_POWER_ON;

	tick_t     tick_q [$];
	led_view_t led_q [$];

	int items_total;
	int beats_in;
	int beats_in_seen;
	int results_done;
	int mismatches;
	int timing_setups = 1;
	int cycles;
	int gap_pct;
	int stall_pct;
	int gap_left;
	int stall_left;
	int hold_left;
	int hold_ask;
	int hold_ack;

	function automatic void map_state(input sys_state_t st, output logic g_hit, output mode_t g,
			output logic r_hit, output mode_t r);
		g_hit = 1'b1;
		r_hit = 1'b1;
		g = MODE_OFF;
		r = MODE_OFF;
		unique case (st)
			ST_INITED: begin
				g = MODE_SLOW;
				r_hit = 1'b0;
			end
			ST_WORKING: begin
				g = MODE_ON;
				r_hit = 1'b0;
			end
			ST_RECONNECT: begin
				g = MODE_FAST;
				r_hit = 1'b0;
			end
			ST_POWER_OFF: begin
				g = MODE_FAST_X3;
				r_hit = 1'b0;
			end
			ST_TESTING: begin
				g = MODE_FAST;
				r = MODE_FAST;
			end
			ST_TEST_OK: begin
				g = MODE_ON;
				r = MODE_ON;
			end
			ST_ERR_ALL: begin
				g = MODE_OFF;
				r = MODE_OFF;
			end
			ST_ERR_MAIN: begin
				g = MODE_OFF;
				r = MODE_ON;
			end
			ST_ERR_EXT: begin
				g = MODE_ON;
				r = MODE_OFF;
			end
			ST_EXT_POWER: begin
				g_hit = 1'b0;
				r = MODE_ON;
			end
			ST_BATT_RELAY: begin
				g_hit = 1'b0;
				r = MODE_SLOW;
			end
			ST_BATT_VLOW: begin
				g_hit = 1'b0;
				r = MODE_FAST;
			end
			ST_BATT_SHUT: begin
				g_hit = 1'b0;
				r = MODE_OFF;
			end
			default: begin
				g_hit = 1'b0;
				r_hit = 1'b0;
			end
		endcase
	endfunction

	function automatic void advance_led(inout led_state_t s, input cfg_word_t slow_on,
			input cfg_word_t slow_per, input cfg_word_t fast_on, input cfg_word_t fast_per);
		logic      slow;
		logic      repeating;
		cfg_word_t on_cnt;
		cfg_word_t per;
		// unknown code: mode drops now, the LED follows a tick later
		if (s.mode > MODE_FAST) begin
			s.mode = MODE_OFF;
			return;
		end
		if (s.mode != s.seen) begin
			s.seen = s.mode;
			s.count = '0;
			if (s.mode >= MODE_SLOW_X1 && s.mode <= MODE_SLOW_X3)
				s.reps = 2'(s.mode - MODE_SLOW_X1 + 1);
			else if (s.mode >= MODE_FAST_X1 && s.mode <= MODE_FAST_X3)
				s.reps = 2'(s.mode - MODE_FAST_X1 + 1);
		end
		if (s.mode == MODE_OFF) begin
			s.level = 1'b0;
			return;
		end
		if (s.mode == MODE_ON) begin
			s.level = 1'b1;
			return;
		end
		slow = s.mode <= MODE_SLOW;
		repeating = s.mode != MODE_SLOW && s.mode != MODE_FAST;
		on_cnt = slow ? slow_on : fast_on;
		per = slow ? slow_per : fast_per;
		if (s.count == '0) begin
			s.level = 1'b1;
		end else if (s.count == on_cnt) begin
			s.level = 1'b0;
		end else if (s.count >= per) begin
			s.count = '0;
			if (repeating) begin
				s.reps = s.reps - 2'd1;
				if (s.reps == 2'd0)
					s.mode = MODE_OFF;
			end
			return;
		end
		s.count = s.count + 1'b1;
	endfunction

	function automatic void predict_tick(tick_t t);
		logic      g_hit;
		logic      r_hit;
		mode_t     g_mode;
		mode_t     r_mode;
		led_view_t v;
		if (t.state_write) begin
			sys_acted = sys_now;
			sys_now = t.new_state;
		end
		if (t.green_write)
			green_st.mode = t.green_mode_in;
		if (t.red_write)
			red_st.mode = t.red_mode_in;
		// map overrides direct writes
		if (sys_now != sys_acted) begin
			map_state(sys_now, g_hit, g_mode, r_hit, r_mode);
			if (g_hit)
				green_st.mode = g_mode;
			if (r_hit)
				red_st.mode = r_mode;
			if (g_hit || r_hit)
				sys_acted = sys_now;
		end
		advance_led(green_st, timing_regs[REG_G_SLOW_ON], timing_regs[REG_G_SLOW_PER],
			timing_regs[REG_G_FAST_ON], timing_regs[REG_G_FAST_PER]);
		advance_led(red_st, timing_regs[REG_R_SLOW_ON], timing_regs[REG_R_SLOW_PER],
			timing_regs[REG_R_FAST_ON], timing_regs[REG_R_FAST_PER]);
		v.green_led = green_st.level;
		v.red_led = red_st.level;
		v.green_mode = green_st.mode;
		v.red_mode = red_st.mode;
		led_q.push_back(v);
	endfunction

	function automatic void report_mismatch(string what, led_view_t want, led_view_t got);
		mismatches++;
		if (mismatches <= SHOWN_MAX)
			$display("[%0t] %s: expected g_led %0b r_led %0b g_mode %0d r_mode %0d, got %s",
				$realtime, what, want.green_led, want.red_led, want.green_mode, want.red_mode,
				$sformatf("g_led %0b r_led %0b g_mode %0d r_mode %0d", got.green_led,
				got.red_led, got.green_mode, got.red_mode));
	endfunction

	// sender: new beat only once the previous one is taken
	always @(negedge clk) begin
		if (!(s_tvalid && beats_in == beats_in_seen)) begin
			if (beats_in != beats_in_seen && gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
				gap_left = $urandom_range(1, 11);
			beats_in_seen = beats_in;
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (tick_q.size() > 0) begin
				s_tdata <= {1'b0, tick_q.pop_front()};
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			predict_tick(tick_t'(s_tdata[14:0]));
			beats_in++;
		end
	end

	// receiver with random stalls and a long hold-off on request
	always @(negedge clk) begin
		if (hold_ask != hold_ack) begin
			hold_ack = hold_ask;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
			stall_left = $urandom_range(0, 10);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		led_view_t got;
		led_view_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = led_view_t'(m_tdata[9:0]);
			results_done++;
			if (led_q.size() == 0) begin
				report_mismatch("result with nothing pending", '0, got);
			end else begin
				want = led_q.pop_front();
				if (got.green_led !== want.green_led || got.red_led !== want.red_led ||
						got.green_mode !== want.green_mode || got.red_mode !== want.red_mode)
					report_mismatch("LED result mismatch", want, got);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d of %0d results seen",
				cycles, results_done, items_total);
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic void push_tick(tick_t t);
		tick_q.push_back(t);
		items_total++;
	endfunction

	function automatic tick_t make_tick(logic sw, sys_state_t st, logic gw, mode_t gm,
			logic rw, mode_t rm);
		tick_t t;
		t.state_write = sw;
		t.new_state = st;
		t.green_write = gw;
		t.green_mode_in = gm;
		t.red_write = rw;
		t.red_mode_in = rm;
		return t;
	endfunction

	// random payload, no writes enabled
	function automatic tick_t quiet_tick();
		tick_t t;
		t = tick_t'($urandom);
		t.state_write = 1'b0;
		t.green_write = 1'b0;
		t.red_write = 1'b0;
		return t;
	endfunction

	function automatic mode_t random_mode();
		if ($urandom_range(0, 4) == 0)
			return mode_t'($urandom_range(MODE_FAST + 1, 15));
		return mode_t'($urandom_range(MODE_OFF, MODE_FAST));
	endfunction

	// one write tick then a run of plain ticks, sometimes raw noise instead
	function automatic void push_burst();
		tick_t t;
		int    kind;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			repeat ($urandom_range(1, 4))
				push_tick(tick_t'($urandom));
			return;
		end
		t = quiet_tick();
		t.state_write = $urandom_range(0, 2) == 0;
		t.green_write = 1'($urandom_range(0, 1));
		t.red_write = 1'($urandom_range(0, 1));
		if (!(t.state_write || t.green_write || t.red_write))
			t.green_write = 1'b1;
		t.green_mode_in = random_mode();
		t.red_mode_in = random_mode();
		push_tick(t);
		repeat ($urandom_range(0, (kind < 5) ? 8 : 30))
			push_tick(quiet_tick());
	endfunction

	function automatic void random_run(int count);
		int start;
		start = items_total;
		while (items_total - start < count)
			push_burst();
	endfunction

	task automatic wait_drained();
		while (results_done < items_total)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, cfg_word_t val);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= APB_DATA_W'(val);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		timing_regs[idx] = val;
		// back-to-back read of the same register
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== APB_DATA_W'(val)) begin
			mismatches++;
			if (mismatches <= SHOWN_MAX)
				$display("[%0t] readback of reg %0d: expected %0h, got %0h",
					$realtime, idx, val, prdata);
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_timing(cfg_word_t gso, cfg_word_t gsp, cfg_word_t gfo, cfg_word_t gfp,
			cfg_word_t rso, cfg_word_t rsp, cfg_word_t rfo, cfg_word_t rfp);
		write_reg(REG_G_SLOW_ON, gso);
		write_reg(REG_G_SLOW_PER, gsp);
		write_reg(REG_G_FAST_ON, gfo);
		write_reg(REG_G_FAST_PER, gfp);
		write_reg(REG_R_SLOW_ON, rso);
		write_reg(REG_R_SLOW_PER, rsp);
		write_reg(REG_R_FAST_ON, rfo);
		write_reg(REG_R_FAST_PER, rfp);
		timing_setups++;
	endtask

	// short on-counts and periods so flashes wrap and repeats run out often
	task automatic random_timing();
		set_timing(CFG_WIDTH'($urandom_range(0, 8)), CFG_WIDTH'($urandom_range(0, 12)),
			CFG_WIDTH'($urandom_range(0, 8)), CFG_WIDTH'($urandom_range(0, 12)),
			CFG_WIDTH'($urandom_range(0, 8)), CFG_WIDTH'($urandom_range(0, 12)),
			CFG_WIDTH'($urandom_range(0, 8)), CFG_WIDTH'($urandom_range(0, 12)));
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset timing: every state and every mode code, map against direct writes
		gap_pct = 25;
		stall_pct = 25;
		push_tick(quiet_tick());
		for (int v = 0; v < 16; v++)
			push_tick(make_tick(1'b1, sys_state_t'(v), 1'b1, mode_t'(v), 1'b1, mode_t'(15 - v)));
		push_tick(make_tick(1'b1, ST_SHUTDOWN, 1'b0, MODE_OFF, 1'b0, MODE_OFF));
		push_tick(quiet_tick());
		random_run(260);
		wait_drained();

		// expired single flash written again right away: no reload, repeat count wraps to 3
		set_timing(2, 4, 1, 2, 3, 5, 0, 3);
		push_tick(make_tick(1'b0, ST_POWER_ON, 1'b1, MODE_FAST_X1, 1'b0, MODE_OFF));
		repeat (2) push_tick(quiet_tick());
		push_tick(make_tick(1'b0, ST_POWER_ON, 1'b1, MODE_FAST_X1, 1'b1, MODE_SLOW_X3));
		repeat (14) push_tick(quiet_tick());
		hold_ask++;
		random_run(260);
		wait_drained();

		// zero on-count, on-count above period, full-scale period
		gap_pct = 40;
		stall_pct = 10;
		set_timing(0, 0, 16'hFFFF, 3, 7, 7, 0, 16'hFFFF);
		push_tick(make_tick(1'b0, ST_POWER_ON, 1'b1, MODE_SLOW, 1'b1, MODE_SLOW));
		repeat (6) push_tick(quiet_tick());
		push_tick(make_tick(1'b0, ST_POWER_ON, 1'b1, MODE_FAST_X3, 1'b1, MODE_FAST));
		repeat (14) push_tick(quiet_tick());
		random_run(120);
		wait_drained();
		random_run(150);
		wait_drained();

		repeat (2) begin
			gap_pct = 20;
			stall_pct = 35;
			random_timing();
			random_run(190);
			wait_drained();
		end

		gap_pct = 0;
		stall_pct = 0;
		random_timing();
		random_run(190);
		wait_drained();
		repeat (8) @(posedge clk);

		$display("Drove %0d ticks over %0d timing setups, %0d LED beats checked, %0d mismatches.",
			items_total, timing_setups, results_done, mismatches);
		$display("Covered all state and mode codes, repeat expiry and re-entry, zero and %s",
			"full-scale timing and a long sink hold-off.");
		if (led_q.size() != 0)
			$display("%0d expected results never arrived", led_q.size());
		if (mismatches == 0 && led_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
